### sv/assert_macros.svh
// Assertion macros used by the RTL of the conductivity block.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the first expression holds, the second holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/ctc_pkg.sv
// Types and constants for the temperature compensated conductivity converter.
// Used by conductivity_temp_compensation, ctc_result_checker and tb_top; depends on nothing else.
package ctc_pkg;

	localparam int NUM_SAMPLES_DEF = 20;
	localparam int ADC_SCALE_DEF   = 1024;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SLOPE = 1'd1;

	localparam logic [12:0] FULL_SCALE_RST = 13'd5000;
	localparam logic [15:0] TEMP_SLOPE_RST = 16'd1212;

	// Coefficient is held times 2^20; 25.0 degrees is 400 sixteenths.
	localparam logic [28:0] COEF_ONE = 29'd1048576;
	localparam logic signed [12:0] TEMP_REF = 13'sd400;

	// Segment boundaries of the compensated voltage, Q8 (448 mV and 1457 mV).
	localparam logic [40:0] SEG_LOW_Q8  = 41'd114688;
	localparam logic [40:0] SEG_HIGH_Q8 = 41'd372992;

	// Gains and offsets of the three segments, Q8.
	localparam logic [10:0] GAIN_LOW  = 11'd1751;
	localparam logic [10:0] GAIN_MID  = 11'd1787;
	localparam logic [10:0] GAIN_HIGH = 11'd1357;
	localparam logic signed [20:0] OFFS_LOW  = -21'sd16466;
	localparam logic signed [20:0] OFFS_MID  = -21'sd32512;
	localparam logic signed [20:0] OFFS_HIGH = 21'sd583168;

	localparam logic [12:0] MV_MAX = 13'd8191;
	localparam logic [32:0] V8_MAX = 33'h1_0000_0000;
	localparam logic signed [16:0] EC_MAX = 17'sd65535;

	typedef struct packed {
		logic [9:0]         adc_sample;
		logic signed [11:0] temp_raw;
	} in_word_t;

	typedef struct packed {
		logic signed [16:0] ec_micro_siemens;
		logic [12:0]        avg_millivolts;
		logic signed [11:0] temp_out;
		logic               coef_error;
	} out_word_t;

endpackage

### sv/conductivity_temp_compensation.sv
// Temperature compensated conductivity converter: batch average, millivolt
// conversion, division by the temperature coefficient and the EC law.
// Depends on ctc_pkg and assert_macros.svh.
//
//   port group   dir  handshake            word
//   in_*         in   in_valid / in_stall  ctc_pkg::in_word_t
//   out_*        out  out_valid / out_stall ctc_pkg::out_word_t
//   cfg_*        in   cfg_we               cfg_index, cfg_data
//
// A sample that does not close a batch is added to the batch sum and count.
// The sample that closes a batch starts a 15-step, a 28-step and a 41-step division
// on one shared restoring divider, plus three steps on one shared multiplier; the
// last division and multiplier step are skipped when the coefficient is not positive.
// Input is stalled during that work and while a finished word waits.
// Reset clears the batch sum, the count and the registers to their defaults.
`include "assert_macros.svh"

module conductivity_temp_compensation #(
	parameter int NUM_SAMPLES = ctc_pkg::NUM_SAMPLES_DEF,
	parameter int ADC_SCALE   = ctc_pkg::ADC_SCALE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ctc_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ctc_pkg::out_word_t                  out_data,
	input  logic                                cfg_we,
	input  logic [ctc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ctc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [4:0]  CNT_HIT  = 5'(NUM_SAMPLES % 32);
	localparam logic [26:0] DIV_NUM  = 27'(NUM_SAMPLES);
	localparam logic [26:0] DIV_ADC  = 27'(ADC_SCALE);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_AVG    = 4'd1;
	localparam logic [3:0] S_MV_MUL = 4'd2;
	localparam logic [3:0] S_MV_DIV = 4'd3;
	localparam logic [3:0] S_COEF   = 4'd4;
	localparam logic [3:0] S_CHK    = 4'd5;
	localparam logic [3:0] S_V8     = 4'd6;
	localparam logic [3:0] S_SEG    = 4'd7;
	localparam logic [3:0] S_EC     = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]  state_q;
	logic [14:0] sum_q;
	logic [4:0]  cnt_q;
	logic [12:0] fs_q;
	logic [15:0] slope_q;
	logic signed [11:0] temp_q;
	logic [12:0] mv_q;
	logic signed [28:0] coef_q;
	logic        err_q;
	logic [32:0] v8_q;
	logic [10:0] gain_q;
	logic signed [20:0] offs_q;
	logic signed [51:0] acc_q;
	logic        out_valid_q;
	ctc_pkg::out_word_t out_q;

	// Shared restoring divider: dividend shifts out the top, quotient in the bottom.
	logic [40:0] dvd_q;
	logic [27:0] rem_q;
	logic [26:0] dsr_q;
	logic [5:0]  step_q;

	logic [27:0] div_shift;
	logic        div_ge;
	logic [27:0] div_rem;

	logic signed [33:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [50:0] mul_p;

	logic [14:0] sum_new;
	logic [4:0]  cnt_new;
	logic        in_acc;
	logic        out_free;
	logic signed [12:0] temp_rel;
	logic signed [35:0] ec_floor;
	logic signed [16:0] ec_val;
	logic        seg_low;
	logic        seg_mid;
	logic        rem_zero;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign sum_new = sum_q + 15'(in_data.adc_sample);
	assign cnt_new = cnt_q + 5'd1;

	assign div_shift = {rem_q[26:0], dvd_q[40]};
	assign div_ge    = (div_shift >= {1'b0, dsr_q});
	assign div_rem   = div_ge ? (div_shift - {1'b0, dsr_q}) : div_shift;

	assign temp_rel = $signed({temp_q[11], temp_q}) - ctc_pkg::TEMP_REF;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MV_MUL: begin
				mul_a = $signed({19'd0, dvd_q[14:0]});
				mul_b = $signed({4'd0, fs_q});
			end
			S_COEF: begin
				mul_a = $signed({18'd0, slope_q});
				mul_b = {{4{temp_rel[12]}}, temp_rel};
			end
			S_EC: begin
				mul_a = $signed({1'b0, v8_q});
				mul_b = $signed({6'd0, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// The exact quotient is at or below a boundary when the integer part is
	// below it, or equal to it with nothing left over.
	assign rem_zero = (rem_q == 28'd0);
	assign seg_low  = (dvd_q < ctc_pkg::SEG_LOW_Q8) ||
		((dvd_q == ctc_pkg::SEG_LOW_Q8) && rem_zero);
	assign seg_mid  = (dvd_q < ctc_pkg::SEG_HIGH_Q8) ||
		((dvd_q == ctc_pkg::SEG_HIGH_Q8) && rem_zero);

	// An arithmetic shift of the sum is the floor of the division by 2^16.
	assign ec_floor = acc_q[51:16];
	assign ec_val   = err_q ? 17'sd0 :
		(ec_floor > 36'(ctc_pkg::EC_MAX)) ? ctc_pkg::EC_MAX : ec_floor[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= ctc_pkg::FULL_SCALE_RST;
			slope_q <= ctc_pkg::TEMP_SLOPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ctc_pkg::REG_FULL_SCALE: fs_q    <= cfg_data[12:0];
				ctc_pkg::REG_TEMP_SLOPE: slope_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new word loaded in the same cycle keeps the output valid.
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cnt_new == CNT_HIT) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_AVG;
						end else begin
							sum_q <= sum_new;
							cnt_q <= cnt_new;
						end
					end
				end
				S_AVG: begin
					if (step_q == 6'd0) begin
						state_q <= S_MV_MUL;
					end
				end
				S_MV_MUL: state_q <= S_MV_DIV;
				S_MV_DIV: begin
					if (step_q == 6'd0) begin
						state_q <= S_COEF;
					end
				end
				S_COEF: state_q <= S_CHK;
				S_CHK: begin
					if (coef_q <= 29'sd0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_V8;
					end
				end
				S_V8: begin
					if (step_q == 6'd0) begin
						state_q <= S_SEG;
					end
				end
				S_SEG: state_q <= S_EC;
				S_EC:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && (cnt_new == CNT_HIT)) begin
					temp_q <= in_data.temp_raw;
					dvd_q  <= {sum_new, 26'd0};
					rem_q  <= '0;
					dsr_q  <= DIV_NUM;
					step_q <= 6'd14;
				end
			end
			S_AVG, S_MV_DIV, S_V8: begin
				dvd_q  <= {dvd_q[39:0], div_ge};
				rem_q  <= div_rem;
				step_q <= step_q - 6'd1;
			end
			S_MV_MUL: begin
				dvd_q  <= {mul_p[27:0], 13'd0};
				rem_q  <= '0;
				dsr_q  <= DIV_ADC;
				step_q <= 6'd27;
			end
			S_COEF: begin
				mv_q   <= (dvd_q[27:13] != 15'd0) ? ctc_pkg::MV_MAX : dvd_q[12:0];
				coef_q <= mul_p[28:0] + $signed(ctc_pkg::COEF_ONE);
			end
			S_CHK: begin
				err_q  <= (coef_q <= 29'sd0);
				dvd_q  <= {mv_q, 28'd0};
				rem_q  <= '0;
				dsr_q  <= coef_q[26:0];
				step_q <= 6'd40;
			end
			S_SEG: begin
				v8_q <= (dvd_q > 41'(ctc_pkg::V8_MAX)) ? ctc_pkg::V8_MAX : dvd_q[32:0];
				if (seg_low) begin
					gain_q <= ctc_pkg::GAIN_LOW;
					offs_q <= ctc_pkg::OFFS_LOW;
				end else if (seg_mid) begin
					gain_q <= ctc_pkg::GAIN_MID;
					offs_q <= ctc_pkg::OFFS_MID;
				end else begin
					gain_q <= ctc_pkg::GAIN_HIGH;
					offs_q <= ctc_pkg::OFFS_HIGH;
				end
			end
			S_EC: begin
				acc_q <= {mul_p[50], mul_p} + {{23{offs_q[20]}}, offs_q, 8'd0};
			end
			S_OUT: begin
				if (out_free) begin
					out_q.ec_micro_siemens <= ec_val;
					out_q.avg_millivolts   <= mv_q;
					out_q.temp_out         <= temp_q;
					out_q.coef_error       <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_ALWAYS(a_cnt_below_hit, (CNT_HIT == 5'd0) || (cnt_q < CNT_HIT),
		"batch count passed its limit")
	`ASSERT_IMPLIES(a_err_zero_ec, out_valid && out_data.coef_error,
		out_data.ec_micro_siemens == 17'sd0, "coefficient error with nonzero EC")
	`ASSERT_IMPLIES(a_out_loaded, (state_q == S_IDLE) && ($past(state_q) == S_OUT),
		out_valid_q, "finished word not presented")
	`ASSERT_IMPLIES(a_div_nonzero,
		(state_q == S_AVG) || (state_q == S_MV_DIV) || (state_q == S_V8),
		dsr_q != 27'd0, "divider runs with zero divisor")

endmodule

### verif/ctc_result_checker.sv
// Result checker for the conductivity converter: watches the sample, result and
// register ports, predicts each batch result and compares it field by field.
// Depends on ctc_pkg.
module ctc_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  ctc_pkg::in_word_t               in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  ctc_pkg::out_word_t              out_data,
	input  logic                            cfg_we,
	input  logic [ctc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              results_due,
	output int                              error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BATCH_LEN = ctc_pkg::NUM_SAMPLES_DEF;
	localparam int ADC_FULL  = ctc_pkg::ADC_SCALE_DEF;

	// Q8 gains and offsets of the three segments of the EC law.
	localparam longint LOW_GAIN   = 1751;
	localparam longint LOW_OFFS   = -16466;
	localparam longint MID_GAIN   = 1787;
	localparam longint MID_OFFS   = -32512;
	localparam longint HIGH_GAIN  = 1357;
	localparam longint HIGH_OFFS  = 583168;
	localparam longint LOW_KNEE   = 448;
	localparam longint HIGH_KNEE  = 1457;
	localparam longint V8_CEILING = 64'h1_0000_0000;

	logic [12:0]        full_scale_mv;
	logic [15:0]        slope_q16;
	logic [14:0]        batch_sum;
	logic [4:0]         batch_count;
	ctc_pkg::out_word_t ec_results_expected[$];

	// Works out the word that a completed batch yields.
	function automatic ctc_pkg::out_word_t predict_batch_result(input logic [12:0] fs,
			input logic [15:0] slope, input logic [14:0] sum, input logic signed [11:0] t);
		longint             avg, mv, coef, v8, gain, offs, ec;
		ctc_pkg::out_word_t r;
		avg  = longint'(sum) / BATCH_LEN;
		mv   = longint'(fs) * avg / ADC_FULL;
		if (mv > 8191)
			mv = 8191;
		coef = (longint'(1) << 20) + longint'(slope) * (longint'(t) - 400);
		ec   = 0;
		r.coef_error = 1'b0;
		if (coef <= 0) begin
			r.coef_error = 1'b1;
		end else begin
			if ((mv << 20) <= LOW_KNEE * coef) begin
				gain = LOW_GAIN;
				offs = LOW_OFFS;
			end else if ((mv << 20) <= HIGH_KNEE * coef) begin
				gain = MID_GAIN;
				offs = MID_OFFS;
			end else begin
				gain = HIGH_GAIN;
				offs = HIGH_OFFS;
			end
			v8 = (mv << 28) / coef;
			if (v8 > V8_CEILING)
				v8 = V8_CEILING;
			// Arithmetic shift gives floor rounding for negative values.
			ec = (gain * v8 + offs * 256) >>> 16;
			if (ec > 65535)
				ec = 65535;
		end
		r.ec_micro_siemens = ec[16:0];
		r.avg_millivolts   = mv[12:0];
		r.temp_out         = t;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ctc_pkg::out_word_t want;
		if (!arst_n) begin
			full_scale_mv = ctc_pkg::FULL_SCALE_RST;
			slope_q16     = ctc_pkg::TEMP_SLOPE_RST;
			batch_sum     = '0;
			batch_count   = '0;
			ec_results_expected.delete();
			results_due   = 0;
			error_count   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				batch_sum   = batch_sum + 15'(in_data.adc_sample);
				batch_count = batch_count + 5'd1;
				if (batch_count == 5'(BATCH_LEN)) begin
					ec_results_expected.push_back(predict_batch_result(full_scale_mv,
						slope_q16, batch_sum, in_data.temp_raw));
					batch_sum   = '0;
					batch_count = '0;
				end
			end
			if (out_valid && !out_stall) begin
				if (ec_results_expected.size() == 0) begin
					$display("%0t: result word with none expected: ec %0d mv %0d temp %0d err %0d",
						$time, out_data.ec_micro_siemens, out_data.avg_millivolts,
						out_data.temp_out, out_data.coef_error);
					error_count++;
				end else begin
					want = ec_results_expected.pop_front();
					if (out_data.ec_micro_siemens !== want.ec_micro_siemens) begin
						$display("%0t: ec_micro_siemens expected %0d got %0d", $time,
							want.ec_micro_siemens, out_data.ec_micro_siemens);
						error_count++;
					end
					if (out_data.avg_millivolts !== want.avg_millivolts) begin
						$display("%0t: avg_millivolts expected %0d got %0d", $time,
							want.avg_millivolts, out_data.avg_millivolts);
						error_count++;
					end
					if (out_data.temp_out !== want.temp_out) begin
						$display("%0t: temp_out expected %0d got %0d", $time,
							want.temp_out, out_data.temp_out);
						error_count++;
					end
					if (out_data.coef_error !== want.coef_error) begin
						$display("%0t: coef_error expected %0d got %0d", $time,
							want.coef_error, out_data.coef_error);
						error_count++;
					end
				end
			end
			// Register writes are to be made only while the block is idle; the block does not enforce it.
			if (cfg_we) begin
				case (cfg_index)
					ctc_pkg::REG_FULL_SCALE: full_scale_mv = cfg_data[12:0];
					ctc_pkg::REG_TEMP_SLOPE: slope_q16 = cfg_data;
					default: ;
				endcase
			end
			results_due = ec_results_expected.size();
		end
	end

endmodule

### verif/tb_top.sv
// Top of the conductivity converter testbench: clock, reset, sample batches,
// register settings and receiver stalls, plus the verdict.
// Depends on ctc_pkg, conductivity_temp_compensation and ctc_result_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int BATCH_LEN     = ctc_pkg::NUM_SAMPLES_DEF;
	localparam int SETTLE_CYCLES = 120;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	ctc_pkg::in_word_t               in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	ctc_pkg::out_word_t              out_data;
	logic                            cfg_we = 1'b0;
	logic [ctc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	int                              results_due;
	int                              error_count;
	int                              idle_pct = 0;
	int                              stall_pct = 0;

	conductivity_temp_compensation uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ctc_result_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.results_due(results_due),
		.error_count(error_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#2ms;
		$display("tb_top failed");
		$finish;
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin idle_pct = 74; stall_pct = 0;  end
			IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 74; end
			default:       begin idle_pct = 10; stall_pct = 10; end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the caller either sends again or drops it.
	task automatic send_word(input ctc_pkg::in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// One full batch: samples spread around a level, the last word carries the
	// temperature that the result is compensated with.
	task automatic send_batch(input int level, input int spread,
			input logic signed [11:0] close_temp);
		ctc_pkg::in_word_t w;
		int                a;
		for (int k = 0; k < BATCH_LEN; k++) begin
			a = level + int'($urandom_range(2 * spread)) - spread;
			if (a < 0)
				a = 0;
			if (a > 1023)
				a = 1023;
			w.adc_sample = a[9:0];
			w.temp_raw   = (k == BATCH_LEN - 1) ? close_temp : 12'($urandom_range(4095));
			send_word(w);
		end
	endtask

	task automatic hold_off();
		in_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [ctc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until no result is due and the settle time has passed, then writes both registers.
	task automatic set_regs(input logic [15:0] fs, input logic [15:0] slope);
		hold_off();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(ctc_pkg::REG_FULL_SCALE, fs);
		write_reg(ctc_pkg::REG_TEMP_SLOPE, slope);
	endtask

	// Mostly ordinary temperatures, some anywhere in the word, and some close
	// to where the coefficient crosses zero.
	function automatic logic signed [11:0] pick_close_temp(input int slope);
		int r;
		int t;
		r = $urandom_range(9);
		t = int'($urandom_range(2880)) - 880;
		if (r >= 6 && r < 8)
			t = int'($urandom_range(4095)) - 2048;
		else if (r >= 8 && slope != 0) begin
			r = 400 - 1048576 / slope + int'($urandom_range(6)) - 3;
			if (r >= -2048 && r <= 2047)
				t = r;
		end
		return 12'(t);
	endfunction

	initial begin
		logic [15:0] fs;
		logic [15:0] slope;
		int          spread;
		set_idling(IDLE_NONE);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full-scale samples at the hottest temperature with reset
		// registers, then empty samples at the coldest, where the coefficient
		// goes negative.
		send_batch(1023, 0, 12'sd2000);
		send_batch(0, 0, -12'sd880);
		// A coefficient of only a few counts makes the voltage clamp and EC saturate.
		set_regs(16'd8191, 16'd65535);
		send_batch(1023, 0, 12'sd384);
		// A coefficient of exactly zero.
		set_regs(16'd8191, 16'd4096);
		send_batch(300, 0, 12'sd144);
		// Smallest scale and a flat slope: zero volts gives the most negative EC.
		set_regs(16'd1, 16'd0);
		send_batch(1023, 0, -12'sd2048);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin fs = 16'd5000; slope = 16'd1212;  end
				1: begin fs = 16'd1;    slope = 16'd0;     end
				2: begin fs = 16'd8191; slope = 16'd65535; end
				3: begin fs = 16'd8191; slope = 16'd0;     end
				4: begin fs = 16'($urandom); slope = 16'($urandom); end
				5: begin fs = 16'd2500; slope = 16'd820;   end
				6: begin fs = 16'($urandom_range(8191, 1)); slope = 16'($urandom_range(4000)); end
				default: begin fs = 16'd1; slope = 16'd65535; end
			endcase
			set_regs(fs, slope);
			set_idling(idle_mode_t'(p % 4));
			for (int b = 0; b < 3; b++) begin
				case ($urandom_range(3))
					0: spread = 0;
					1: spread = 4;
					2: spread = 200;
					default: spread = 1023;
				endcase
				send_batch($urandom_range(1023), spread, pick_close_temp(slope));
				// In this phase the sender waits for each result before going on.
				if (p == 5)
					hold_off();
			end
		end

		hold_off();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
